// ===== rtl/core/ovbw_pkg.sv =====
`default_nettype none

package ovbw_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_OVERLAY_ENABLE = 3'd0;
   localparam logic [2:0] CSR_FRAME_WIDTH    = 3'd1;
   localparam logic [2:0] CSR_FRAME_HEIGHT   = 3'd2;
   localparam logic [2:0] CSR_WINDOW_WIDTH   = 3'd3;
   localparam logic [2:0] CSR_WINDOW_HEIGHT  = 3'd4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;
   localparam int POS_W       = 10;

   // reset values of the configuration registers
   localparam logic           RST_OVERLAY_ENABLE = 1'b0;
   localparam logic [POS_W-1:0] RST_FRAME_WIDTH  = 10'd160;
   localparam logic [POS_W-1:0] RST_FRAME_HEIGHT = 10'd144;
   localparam logic [POS_W-1:0] RST_WINDOW_WIDTH = 10'd80;
   localparam logic [POS_W-1:0] RST_WINDOW_HEIGHT = 10'd64;

   // classified pixel, front to back
   typedef struct packed {
      logic [15:0] frame_pixel;
      logic [31:0] overlay_word;
      logic        blend;
      logic        frame_end;
   } ovbw_item_type;

   // finished pixel, back to result queue
   typedef struct packed {
      logic [15:0] pixel_out;
      logic        frame_end;
   } ovbw_result_type;

   // back end status for checking
   typedef struct packed {
      logic take;
      logic stage_valid;
   } ovbw_back_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/ovbw_queue.sv =====
`default_nettype none

module ovbw_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire logic [WIDTH-1:0]             push_data,
   output      logic                         full,
   input  wire logic                         pop,
   output      logic [WIDTH-1:0]             pop_data,
   output      logic                         empty,
   output      logic [$clog2(DEPTH+1)-1:0]   level
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LVL_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == LVL_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign level    = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ovbw_front.sv =====
`default_nettype none

module ovbw_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               valid,
   output      logic                               ready,
   input  wire logic [ovbw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [ovbw_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire logic                               push,
   output      logic                               full,
   input  wire logic [15:0]                        req_frame_pixel,
   input  wire logic [31:0]                        req_overlay_word,
   input  wire logic                               mid_full,
   output      logic                               mid_push,
   output      ovbw_pkg::ovbw_item_type            mid_item
);

   localparam int PW = ovbw_pkg::POS_W;

   logic          enable_ff, enable_in;
   logic [PW-1:0] frame_w_ff, frame_w_in;
   logic [PW-1:0] frame_h_ff, frame_h_in;
   logic [PW-1:0] win_w_ff, win_w_in;
   logic [PW-1:0] win_h_ff, win_h_in;
   logic [PW-1:0] col_ff, col_in;
   logic [PW-1:0] row_ff, row_in;
   logic          accept, last_col, last_row, in_window;

   assign ready    = 1'b1;
   assign full     = mid_full;
   assign accept   = push && !mid_full;
   assign mid_push = accept;

   // size of zero behaves as one through the compare
   assign last_col  = ({1'b0, col_ff} + 11'd1) >= {1'b0, frame_w_ff};
   assign last_row  = ({1'b0, row_ff} + 11'd1) >= {1'b0, frame_h_ff};
   assign in_window = enable_ff && (col_ff < win_w_ff) && (row_ff < win_h_ff);

   always_comb begin
      mid_item.frame_pixel  = req_frame_pixel;
      mid_item.overlay_word = req_overlay_word;
      mid_item.blend        = in_window;
      mid_item.frame_end    = last_col && last_row;
   end

   always_comb begin
      enable_in  = enable_ff;
      frame_w_in = frame_w_ff;
      frame_h_in = frame_h_ff;
      win_w_in   = win_w_ff;
      win_h_in   = win_h_ff;
      if (valid) begin
         unique case (csr_index)
            ovbw_pkg::CSR_OVERLAY_ENABLE: enable_in  = csr_data[0];
            ovbw_pkg::CSR_FRAME_WIDTH:    frame_w_in = csr_data;
            ovbw_pkg::CSR_FRAME_HEIGHT:   frame_h_in = csr_data;
            ovbw_pkg::CSR_WINDOW_WIDTH:   win_w_in   = csr_data;
            ovbw_pkg::CSR_WINDOW_HEIGHT:  win_h_in   = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= ovbw_pkg::RST_OVERLAY_ENABLE;
         frame_w_ff <= ovbw_pkg::RST_FRAME_WIDTH;
         frame_h_ff <= ovbw_pkg::RST_FRAME_HEIGHT;
         win_w_ff   <= ovbw_pkg::RST_WINDOW_WIDTH;
         win_h_ff   <= ovbw_pkg::RST_WINDOW_HEIGHT;
         col_ff     <= '0;
         row_ff     <= '0;
      end else begin
         enable_ff  <= enable_in;
         frame_w_ff <= frame_w_in;
         frame_h_ff <= frame_h_in;
         win_w_ff   <= win_w_in;
         win_h_ff   <= win_h_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ovbw_back.sv =====
`default_nettype none

module ovbw_back #(
   parameter int OUT_DEPTH = 4
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               mid_empty,
   input  wire ovbw_pkg::ovbw_item_type            mid_item,
   output      logic                               mid_pop,
   input  wire logic [$clog2(OUT_DEPTH+1)-1:0]     out_level,
   output      logic                               out_push,
   output      ovbw_pkg::ovbw_result_type          out_result,
   output      ovbw_pkg::ovbw_back_status_type     status
);

   localparam int LVL_W = $clog2(OUT_DEPTH + 1);

   logic        take;
   logic [LVL_W:0] credit_used;
   logic [7:0]  bg_r, bg_g, bg_b, ov_r, ov_g, ov_b;
   logic [7:0]  alpha, inv_alpha;
   logic [8:0]  inv_wide;
   logic [15:0] p_bg_r, p_bg_g, p_bg_b, p_ov_r, p_ov_g, p_ov_b;
   logic [16:0] r_sum_in, g_sum_in, b_sum_in;
   logic [16:0] r_sum_ff, g_sum_ff, b_sum_ff;
   logic [15:0] pass_ff;
   logic        blend_ff, frame_end_ff, stage_valid_ff;
   logic [15:0] red_part, green_part, blue_part, packed_px;

   // only take an item when the result queue is sure to have room for it
   assign credit_used = {1'b0, out_level} + {{LVL_W{1'b0}}, stage_valid_ff};
   assign take        = !mid_empty && (credit_used < (LVL_W + 1)'(OUT_DEPTH));
   assign mid_pop     = take;

   assign bg_r = {mid_item.frame_pixel[15:11], 3'b000};
   assign bg_g = {mid_item.frame_pixel[10:5], 2'b00};
   assign bg_b = {mid_item.frame_pixel[4:0], 3'b000};
   assign ov_r = mid_item.overlay_word[7:0];
   assign ov_g = mid_item.overlay_word[15:8];
   assign ov_b = mid_item.overlay_word[23:16];

   // a/2 + 128 always has its top bit set
   assign alpha     = {1'b1, mid_item.overlay_word[31:25]};
   assign inv_wide  = 9'd256 - {1'b0, alpha};
   assign inv_alpha = inv_wide[7:0];

   assign p_bg_r = {8'b0, bg_r} * {8'b0, inv_alpha};
   assign p_bg_g = {8'b0, bg_g} * {8'b0, inv_alpha};
   assign p_bg_b = {8'b0, bg_b} * {8'b0, inv_alpha};
   assign p_ov_r = {8'b0, ov_r} * {8'b0, alpha};
   assign p_ov_g = {8'b0, ov_g} * {8'b0, alpha};
   assign p_ov_b = {8'b0, ov_b} * {8'b0, alpha};

   assign r_sum_in = {1'b0, p_bg_r} + {1'b0, p_ov_r};
   assign g_sum_in = {1'b0, p_bg_g} + {1'b0, p_ov_g};
   assign b_sum_in = {1'b0, p_bg_b} + {1'b0, p_ov_b};

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         r_sum_ff     <= r_sum_in;
         g_sum_ff     <= g_sum_in;
         b_sum_ff     <= b_sum_in;
         pass_ff      <= mid_item.frame_pixel;
         blend_ff     <= mid_item.blend;
         frame_end_ff <= mid_item.frame_end;
      end
   end

   // repack to 565; blended results also have their bytes swapped
   assign red_part   = {r_sum_ff[15:11], 11'b0};
   assign green_part = {4'b0, g_sum_ff[16:10], 5'b0};
   assign blue_part  = {10'b0, b_sum_ff[16:11]};
   assign packed_px  = red_part + green_part + blue_part;

   assign out_push = stage_valid_ff;

   always_comb begin
      out_result.pixel_out = blend_ff ? {packed_px[7:0], packed_px[15:8]} : pass_ff;
      out_result.frame_end = frame_end_ff;
   end

   always_comb begin
      status.take        = take;
      status.stage_valid = stage_valid_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/core/overlay_alpha_blend_window_unit.sv =====
`default_nettype none

// overlay alpha blend over a top-left window of an rgb565 raster stream.
// pixels go in through a queue-style port (push/full) with their abgr8888
// overlay word and come out through a queue-style port (empty/pop), one result
// per pixel, in order. the unit keeps column and row counters that wrap at the
// programmed frame size; inside the window (and with the overlay enabled) the
// pixel is blended with alpha remapped to a/2+128 and returned as byte-swapped
// rgb565, elsewhere it passes unchanged. frame_end marks the last pixel of a
// frame. throughput is one pixel per clock, sustained, as long as pop keeps
// up: the front end classifies a pixel in the cycle it is accepted, and the
// back end runs the six 8x8 multiplies in a single registered stage. a result
// reaches rsp via the middle queue, the blend stage register and the result queue.
// configuration writes are always taken (ready tied high) and should only be
// made while the unit is drained; they never reset the position counters.

module overlay_alpha_blend_window_unit #(
   parameter int MID_DEPTH = 4,   // classified pixels between front and back
   parameter int OUT_DEPTH = 4    // finished results waiting for pop
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // configuration write channel
   input  wire logic                               valid,
   output      logic                               ready,
   input  wire logic [ovbw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [ovbw_pkg::CSR_DATA_W-1:0]    csr_data,
   // pixel input
   input  wire logic                               push,
   output      logic                               full,
   input  wire logic [15:0]                        req_frame_pixel,
   input  wire logic [31:0]                        req_overlay_word,
   // result output
   output      logic                               empty,
   input  wire logic                               pop,
   output      logic [15:0]                        rsp_pixel_out,
   output      logic                               rsp_frame_end
);

   localparam int ITEM_W = $bits(ovbw_pkg::ovbw_item_type);
   localparam int RES_W  = $bits(ovbw_pkg::ovbw_result_type);

   // front to middle queue
   logic                              mid_push, mid_full, mid_empty, mid_pop;
   ovbw_pkg::ovbw_item_type           mid_wr_item, mid_rd_item;
   logic [ITEM_W-1:0]                 mid_wr_bits, mid_rd_bits;
   logic [$clog2(MID_DEPTH+1)-1:0]    mid_level;

   // back to result queue
   logic                              out_push, out_full;
   ovbw_pkg::ovbw_result_type         out_wr_result, out_rd_result;
   logic [RES_W-1:0]                  out_rd_bits;
   logic [$clog2(OUT_DEPTH+1)-1:0]    out_level;
   ovbw_pkg::ovbw_back_status_type    back_status;

   // front end: registers, position counters, window and frame end decision
   ovbw_front u_front (
      .clock            (clock),
      .reset            (reset),
      .valid            (valid),
      .ready            (ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .push             (push),
      .full             (full),
      .req_frame_pixel  (req_frame_pixel),
      .req_overlay_word (req_overlay_word),
      .mid_full         (mid_full),
      .mid_push         (mid_push),
      .mid_item         (mid_wr_item)
   );

   assign mid_wr_bits = mid_wr_item;
   assign mid_rd_item = ovbw_pkg::ovbw_item_type'(mid_rd_bits);

   // decouples classification from the blend stage
   ovbw_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_wr_bits),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_rd_bits),
      .empty     (mid_empty),
      .level     (mid_level)
   );

   // back end: blend stage with credit check against the result queue
   ovbw_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .mid_empty  (mid_empty),
      .mid_item   (mid_rd_item),
      .mid_pop    (mid_pop),
      .out_level  (out_level),
      .out_push   (out_push),
      .out_result (out_wr_result),
      .status     (back_status)
   );

   // result queue, head drives the rsp ports
   ovbw_queue #(
      .WIDTH (RES_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_wr_result),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (out_rd_bits),
      .empty     (empty),
      .level     (out_level)
   );

   assign out_rd_result = ovbw_pkg::ovbw_result_type'(out_rd_bits);
   assign rsp_pixel_out = out_rd_result.pixel_out;
   assign rsp_frame_end = out_rd_result.frame_end;

   // a pixel in the blend stage always has a free slot waiting for it
   a_stage_has_room: assert property (@(posedge clock) disable iff (reset)
      back_status.stage_valid |-> !out_full)
      else $error("blend stage holds a result but the result queue is full");

   // every transaction taken by the back end lands in the blend stage
   a_take_fills_stage: assert property (@(posedge clock) disable iff (reset)
      back_status.take |=> back_status.stage_valid)
      else $error("back end took a pixel that did not reach the blend stage");

   // an accepted pixel is held in the middle queue on the next cycle
   a_accept_queued: assert property (@(posedge clock) disable iff (reset)
      (push && !full) |=> (mid_level != '0))
      else $error("accepted transaction missing from the middle queue");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int MAX_PAUSE    = 19;
   localparam int DRAIN_CYCLES = 6;     // extra wait after the last result has been popped
   localparam int HOLD_CYCLES  = 400;   // long receiver hold-off so the unit fills up
   localparam int HOLD_AFTER   = 300;   // results seen before the hold-off starts
   localparam int PHASE_PIXELS = 100;
   localparam int PHASES       = 9;
   localparam logic [ovbw_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED = 3'd7;

   typedef struct packed {
      logic [15:0] frame_pixel;
      logic [31:0] overlay_word;
   } pixel_in_type;

   logic                             clock;
   logic                             reset;
   logic                             valid;
   logic                             ready;
   logic [ovbw_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [ovbw_pkg::CSR_DATA_W-1:0]  csr_data;
   logic                             push;
   logic                             full;
   logic [15:0]                      req_frame_pixel;
   logic [31:0]                      req_overlay_word;
   logic                             empty;
   logic                             pop;
   logic [15:0]                      rsp_pixel_out;
   logic                             rsp_frame_end;

   overlay_alpha_blend_window_unit dut (
      .clock            (clock),
      .reset            (reset),
      .valid            (valid),
      .ready            (ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .push             (push),
      .full             (full),
      .req_frame_pixel  (req_frame_pixel),
      .req_overlay_word (req_overlay_word),
      .empty            (empty),
      .pop              (pop),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_frame_end    (rsp_frame_end)
   );

   // shadow copy of the unit's registers and raster position
   logic                       shd_enable;
   logic [ovbw_pkg::POS_W-1:0] shd_frame_w;
   logic [ovbw_pkg::POS_W-1:0] shd_frame_h;
   logic [ovbw_pkg::POS_W-1:0] shd_win_w;
   logic [ovbw_pkg::POS_W-1:0] shd_win_h;
   logic [ovbw_pkg::POS_W-1:0] shd_col;
   logic [ovbw_pkg::POS_W-1:0] shd_row;

   pixel_in_type              pending_pixels[$];    // pixels still to be offered
   ovbw_pkg::ovbw_result_type expected_pixels[$];   // predicted results, oldest first
   ovbw_pkg::ovbw_result_type oldest;
   pixel_in_type              next_pixel;

   // driver and monitor bookkeeping
   bit offering;
   bit req_taken;
   bit req_burst;
   int req_pause;
   bit rsp_taken;
   bit rsp_burst;
   int rsp_pause;
   bit rsp_hold;
   int results_seen;
   int errors;
   int cycle_count;

   // clock: 8 ns period
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // blend one rgb565 pixel with an abgr8888 overlay word, result byte-swapped
   function automatic logic [15:0] blend_rgb565(logic [15:0] px, logic [31:0] ov);
      int unsigned alpha;
      int unsigned keep;
      int unsigned red;
      int unsigned green;
      int unsigned blue;
      logic [15:0] packed_px;
      alpha     = 32'(ov[31:24] >> 1);
      alpha     = alpha + 128;   // alpha remapped to a/2 + 128
      keep      = 256 - alpha;
      red       = 32'({px[15:11], 3'b000}) * keep + 32'(ov[7:0]) * alpha;
      green     = 32'({px[10:5], 2'b00}) * keep + 32'(ov[15:8]) * alpha;
      blue      = 32'({px[4:0], 3'b000}) * keep + 32'(ov[23:16]) * alpha;
      packed_px = {red[15:11], green[15:10], blue[15:11]};
      return {packed_px[7:0], packed_px[15:8]};
   endfunction

   // expected result for the pixel at the current raster position, then advance
   function automatic ovbw_pkg::ovbw_result_type predict_pixel(pixel_in_type px);
      ovbw_pkg::ovbw_result_type res;
      logic last_col;
      logic last_row;
      logic in_window;
      // a zero size acts as one, and a position past a shrunk frame counts as last
      last_col  = ({1'b0, shd_col} + 11'd1) >= {1'b0, shd_frame_w};
      last_row  = ({1'b0, shd_row} + 11'd1) >= {1'b0, shd_frame_h};
      in_window = shd_enable && (shd_col < shd_win_w) && (shd_row < shd_win_h);
      res.pixel_out = in_window ? blend_rgb565(px.frame_pixel, px.overlay_word)
                                : px.frame_pixel;
      res.frame_end = last_col && last_row;
      if (last_col) begin
         shd_col = '0;
         shd_row = last_row ? '0 : shd_row + 1'b1;
      end else begin
         shd_col = shd_col + 1'b1;
      end
      return res;
   endfunction

   // monitor: everything is sampled at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         shd_enable  = ovbw_pkg::RST_OVERLAY_ENABLE;
         shd_frame_w = ovbw_pkg::RST_FRAME_WIDTH;
         shd_frame_h = ovbw_pkg::RST_FRAME_HEIGHT;
         shd_win_w   = ovbw_pkg::RST_WINDOW_WIDTH;
         shd_win_h   = ovbw_pkg::RST_WINDOW_HEIGHT;
         shd_col     = '0;
         shd_row     = '0;
      end else begin
         // register write transaction; unmapped indexes change nothing
         if (valid && ready) begin
            case (csr_index)
               ovbw_pkg::CSR_OVERLAY_ENABLE: shd_enable  = csr_data[0];
               ovbw_pkg::CSR_FRAME_WIDTH:    shd_frame_w = csr_data;
               ovbw_pkg::CSR_FRAME_HEIGHT:   shd_frame_h = csr_data;
               ovbw_pkg::CSR_WINDOW_WIDTH:   shd_win_w   = csr_data;
               ovbw_pkg::CSR_WINDOW_HEIGHT:  shd_win_h   = csr_data;
               default: ;
            endcase
         end
         // pixel transaction accepted
         if (push && !full) begin
            expected_pixels.push_back(predict_pixel({req_frame_pixel, req_overlay_word}));
            req_taken = 1'b1;
         end
         // result transaction accepted: compare against the oldest prediction
         if (pop && !empty) begin
            rsp_taken = 1'b1;
            results_seen++;
            if (expected_pixels.size() == 0) begin
               $error("unexpected result: pixel_out %h frame_end %b",
                      rsp_pixel_out, rsp_frame_end);
               errors++;
            end else begin
               oldest = expected_pixels.pop_front();
               if (rsp_pixel_out !== oldest.pixel_out) begin
                  $error("pixel_out: expected %h, got %h", oldest.pixel_out, rsp_pixel_out);
                  errors++;
               end
               if (rsp_frame_end !== oldest.frame_end) begin
                  $error("frame_end: expected %b, got %b", oldest.frame_end, rsp_frame_end);
                  errors++;
               end
            end
         end
      end
   end

   // pixel driver: changes on the falling edge, random gap after every transaction outside bursts
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (req_taken) begin
            req_taken = 1'b0;
            offering  = 1'b0;
            // now and then switch between gappy traffic and back-to-back bursts
            if ($urandom_range(0, 39) == 0)
               req_burst = !req_burst;
            req_pause = req_burst ? 0 : $urandom_range(0, MAX_PAUSE);
         end
         if (!offering) begin
            if (req_pause > 0) begin
               req_pause--;
            end else if (pending_pixels.size() != 0) begin
               next_pixel = pending_pixels.pop_front();
               offering   = 1'b1;
            end
         end
         push             <= offering;
         req_frame_pixel  <= next_pixel.frame_pixel;
         req_overlay_word <= next_pixel.overlay_word;
      end
   end

   // result receiver: random stall after every transaction outside bursts, plus the long hold-off
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            if ($urandom_range(0, 39) == 0)
               rsp_burst = !rsp_burst;
            rsp_pause = rsp_burst ? 0 : $urandom_range(0, MAX_PAUSE);
         end
         if (rsp_pause > 0) begin
            rsp_pause--;
            pop <= 1'b0;
         end else begin
            pop <= !rsp_hold;
         end
      end
   end

   // back-pressure: stop popping for a long stretch while pixels keep coming
   initial begin
      while (results_seen < HOLD_AFTER)
         @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench NOT OK");
      $finish;
   end

   // one register write transaction, valid lowered on the next falling edge
   task automatic write_csr(input logic [ovbw_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [ovbw_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      valid     <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!ready);
      @(negedge clock);
      valid <= 1'b0;
   endtask

   // program every register; only bit 0 of the enable counts, so the rest is noise
   task automatic configure(input logic en,
                            input logic [ovbw_pkg::CSR_DATA_W-1:0] fw,
                            input logic [ovbw_pkg::CSR_DATA_W-1:0] fh,
                            input logic [ovbw_pkg::CSR_DATA_W-1:0] ww,
                            input logic [ovbw_pkg::CSR_DATA_W-1:0] wh);
      write_csr(ovbw_pkg::CSR_OVERLAY_ENABLE, {9'($urandom), en});
      write_csr(ovbw_pkg::CSR_FRAME_WIDTH, fw);
      write_csr(ovbw_pkg::CSR_FRAME_HEIGHT, fh);
      write_csr(ovbw_pkg::CSR_WINDOW_WIDTH, ww);
      write_csr(ovbw_pkg::CSR_WINDOW_HEIGHT, wh);
      write_csr(CSR_UNMAPPED, 10'($urandom));   // must be ignored
   endtask

   task automatic queue_pixel(input logic [15:0] px, input logic [31:0] ov);
      pending_pixels.push_back('{px, ov});
   endtask

   // let every queued pixel through and every result out before touching registers
   task automatic wait_drained();
      while (pending_pixels.size() != 0 || push || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // stimulus
   initial begin : stimulus
      logic [ovbw_pkg::CSR_DATA_W-1:0] fw;
      logic [ovbw_pkg::CSR_DATA_W-1:0] fh;
      logic [31:0]                     ov;

      // every input known from time zero
      reset            = 1'b1;
      valid            = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      push             = 1'b0;
      pop              = 1'b0;
      req_frame_pixel  = '0;
      req_overlay_word = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: 4x3 frame with a 2x2 window
      configure(1'b1, 10'd4, 10'd3, 10'd2, 10'd2);
      queue_pixel(16'h0000, 32'h0000_0000);   // zero alpha still gives the overlay half weight
      queue_pixel(16'hFFFF, 32'hFFFF_FFFF);   // full alpha, all ones
      queue_pixel(16'hFFFF, 32'hFF12_3456);   // right of the window, passes
      queue_pixel(16'h0000, 32'hFFFF_FFFF);
      queue_pixel(16'hF800, 32'h7F00_00FF);   // pure red background
      queue_pixel(16'h07E0, 32'h80FF_00FF);   // pure green background
      queue_pixel(16'h001F, 32'h0100_FF00);   // pure blue, outside the window
      wait_drained();

      // frame narrowed under the column counter: column 3 now counts as last
      write_csr(ovbw_pkg::CSR_FRAME_WIDTH, 10'd2);
      queue_pixel(16'hA5A5, 32'hC0FF_FFFF);
      queue_pixel(16'h5A5A, 32'h4000_0000);
      wait_drained();

      // frame shortened under the row counter: row 2 now counts as last
      write_csr(ovbw_pkg::CSR_FRAME_HEIGHT, 10'd1);
      queue_pixel(16'h1234, 32'hFFAB_CDEF);   // frame end, wraps to the origin
      queue_pixel(16'hFEDC, 32'h00FF_FFFF);   // back inside the window
      queue_pixel(16'h8001, 32'hFF00_0000);
      wait_drained();

      // zero frame size acts as one pixel: every pixel ends a frame
      configure(1'b0, 10'd0, 10'd0, 10'd1023, 10'd1023);
      queue_pixel(16'hFFFF, 32'hFFFF_FFFF);
      queue_pixel(16'h0000, 32'h0000_0000);
      queue_pixel(16'h7BEF, 32'h8080_8080);
      wait_drained();

      // window larger than the frame: every pixel is blended
      configure(1'b1, 10'd0, 10'd0, 10'd1023, 10'd1023);
      queue_pixel(16'hFFFF, 32'h0000_0000);
      queue_pixel(16'h0000, 32'hFFFF_FFFF);
      queue_pixel(16'h7BEF, 32'h8080_8080);
      wait_drained();

      // empty window: nothing is blended even with the overlay on
      configure(1'b1, 10'd5, 10'd2, 10'd0, 10'd0);
      queue_pixel(16'hFFFF, 32'hFFFF_FFFF);
      queue_pixel(16'h0000, 32'hFF00_0000);
      queue_pixel(16'hC3C3, 32'h3C3C_3C3C);
      wait_drained();

      // random phases, mostly small frames so wraps and window edges come often
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: configure(1'b1, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
            1: configure(1'b1, 10'd1, 10'd1, 10'd1023, 10'd0);
            2: configure(1'b0, 10'd7, 10'd3, 10'd5, 10'd2);
            default: begin
               fw = 10'($urandom_range(0, 12));
               fh = 10'($urandom_range(0, 8));
               configure($urandom_range(0, 3) != 0, fw, fh,
                         10'($urandom_range(0, fw + 2)), 10'($urandom_range(0, fh + 2)));
            end
         endcase
         repeat (PHASE_PIXELS) begin
            ov = $urandom;
            // bias alpha towards its extremes
            case ($urandom_range(0, 3))
               0: ov[31:24] = 8'h00;
               1: ov[31:24] = 8'hFF;
               default: ;
            endcase
            queue_pixel(16'($urandom), ov);
         end
         wait_drained();
      end

      if (errors == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/ovbw_pkg.sv
rtl/core/ovbw_queue.sv
rtl/core/ovbw_front.sv
rtl/core/ovbw_back.sv
rtl/core/overlay_alpha_blend_window_unit.sv
tb/testbench.sv
